>>> rtl/harris_corner_score_unit_assert.svh
// Assertion macros used by the checker file hcs_checker.sv.
`ifndef HARRIS_CORNER_SCORE_UNIT_ASSERT_SVH
`define HARRIS_CORNER_SCORE_UNIT_ASSERT_SVH
// Implication that must hold at every clock edge out of reset.
`define HCS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hcs check failed");
// Next-cycle implication.
`define HCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hcs check failed");
`endif

>>> rtl/hcs_pkg.sv
// ---------------------------------------------------------------------------
// hcs_pkg
// Shared constants, types and helpers of the Harris corner score unit.
// ---------------------------------------------------------------------------
`default_nettype none
package hcs_pkg;
  localparam int unsigned MaxWidthDef  = 2048;
  localparam int unsigned MaxHeightDef = 4095;
  localparam int unsigned CfgW   = 12;
  localparam int unsigned PixW   = 8;
  localparam int unsigned ProdW  = 16;
  localparam int unsigned ScoreW = 32;
  localparam int unsigned RowW   = 12;
  localparam int unsigned ColW   = 11;

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  // Control carried alongside each word down the pipeline.
  typedef struct packed {
    logic          vld;
    logic          emit;
    logic          last;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } ctl_t;
endpackage
`default_nettype wire

>>> rtl/hcs_ram.sv
// ---------------------------------------------------------------------------
// hcs_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module hcs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

>>> rtl/harris_corner_score_unit.sv
// ---------------------------------------------------------------------------
// harris_corner_score_unit
// Scharr gradients, 1-2-1 smoothed structure products and Harris response
// over a raster pixel stream.
// ---------------------------------------------------------------------------
// channel   direction  handshake            payload
// pixel     in         pixel_valid_i/ready  pixel_i
// score     out        score_valid_o/ready  score_o, score_row_o, score_col_o,
//                                           frame_last_o
// config    in         cfg_we_i             cfg_idx_i, cfg_data_i
//
// One pixel per cycle while the output is not stalled; eleven register stages
// (s1 to s11), so a score word is presented once the pixel completing its
// window has passed through all of them, and can leave at the next edge. The whole pipeline
// advances together on one enable: a stalled output freezes every stage, so nothing is lost.
// Line stores are synchronous RAMs read ahead of use: the pixel read is
// issued at acceptance, the product read from stage 2 so that its data lands
// with the stage-3 products. The pixel line store is cleared after reset by a
// sweep of all MAX_WIDTH addresses, during which no pixel is accepted.
// ---------------------------------------------------------------------------
`default_nettype none
module harris_corner_score_unit #(
  parameter int unsigned MAX_WIDTH  = hcs_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = hcs_pkg::MaxHeightDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [0:0]                  cfg_idx_i,
  input  wire logic [hcs_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic                        pixel_valid_i,
  output logic                             pixel_ready_o,
  input  wire logic [hcs_pkg::PixW-1:0]    pixel_i,
  output logic                             score_valid_o,
  input  wire logic                        score_ready_i,
  output logic signed [hcs_pkg::ScoreW-1:0] score_o,
  output logic [hcs_pkg::RowW-1:0]         score_row_o,
  output logic [hcs_pkg::ColW-1:0]         score_col_o,
  output logic                             frame_last_o
);
  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned CW  = hcs_pkg::ColW;
  localparam int unsigned RW  = hcs_pkg::RowW;
  localparam int unsigned NST = 11;

  // Configuration registers.
  logic [hcs_pkg::CfgW-1:0] width_q, height_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= hcs_pkg::CfgW'(640);
      height_q <= hcs_pkg::CfgW'(480);
    end else if (cfg_we_i) begin
      unique case (hcs_pkg::cfg_idx_e'(cfg_idx_i))
        hcs_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
        hcs_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamped sizes (17 bits, wider than the parameter range needs).
  logic [16:0] w_eff, h_eff;
  always_comb begin
    w_eff = 17'(width_q);
    if (w_eff == '0) w_eff = 17'd1;
    if (w_eff > 17'(MAX_WIDTH)) w_eff = 17'(MAX_WIDTH);
    h_eff = 17'(height_q);
    if (h_eff == '0) h_eff = 17'd1;
    if (h_eff > 17'(MAX_HEIGHT)) h_eff = 17'(MAX_HEIGHT);
  end

  // Pipeline advance: hold everything while the output word is stalled.
  logic adv;
  logic clr_busy_q;
  logic [AW:0] clr_cnt_q;
  assign adv = !score_valid_o || score_ready_i;
  assign pixel_ready_o = adv && !clr_busy_q;
  logic acc;
  assign acc = pixel_valid_i && pixel_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == (AW+1)'(MAX_WIDTH - 1)) clr_busy_q <= 1'b0;
    end
  end

  // Raster counters; wrap applied before use, as incoming.
  logic [16:0] col_q, row_q;
  logic [16:0] c_cur, r_cur;
  always_comb begin
    c_cur = col_q;
    r_cur = row_q;
    if (c_cur >= w_eff) begin
      c_cur = '0;
      r_cur = r_cur + 17'd1;
    end
    if (r_cur >= h_eff) r_cur = '0;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      col_q <= c_cur + 17'd1;
      row_q <= r_cur;
    end
  end

  // Stage 1: pixel line store read issued at acceptance.
  logic [AW-1:0] c_addr;
  assign c_addr = AW'(c_cur);
  logic [2*hcs_pkg::PixW-1:0] pls_rd;
  logic        s1_vld_q;
  logic [AW-1:0] s1_addr_q;
  logic [7:0]  s1_pix_q;
  logic        s1_grad_q, s1_emit_q, s1_last_q;
  logic [RW-1:0] s1_row_q;
  logic [CW-1:0] s1_col_q;
  logic [15:0] pls_byp;
  logic        byp_q;
  logic [15:0] byp_data_q;

  // Bypass: the same column read twice in a row only if width is 1.
  hcs_ram #(.Width(2*hcs_pkg::PixW), .Depth(MAX_WIDTH)) u_pix_line (
    .clk_i   (clk_i),
    .we_i    (clr_busy_q || (s1_vld_q && adv)),
    .waddr_i (clr_busy_q ? AW'(clr_cnt_q) : s1_addr_q),
    .wdata_i (clr_busy_q ? '0 : {s1_pix_q, pls_byp[15:8]}),
    .re_i    (acc),
    .raddr_i (c_addr),
    .rdata_o (pls_rd)
  );
  assign pls_byp = byp_q ? byp_data_q : pls_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      byp_q    <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= acc;
      byp_q    <= acc && s1_vld_q && (s1_addr_q == c_addr);
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      byp_data_q <= {s1_pix_q, pls_byp[15:8]};
      if (acc) begin
        s1_addr_q <= c_addr;
        s1_pix_q  <= pixel_i;
        s1_grad_q <= (r_cur >= 17'd2) && (c_cur >= 17'd2);
        s1_emit_q <= (r_cur >= 17'd4) && (c_cur >= 17'd4);
        s1_last_q <= (r_cur == h_eff - 17'd1) && (c_cur == w_eff - 17'd1);
        s1_row_q  <= RW'(r_cur - 17'd2);
        s1_col_q  <= CW'(c_cur - 17'd2);
      end
    end
  end

  // Pixel window: [col][row], col 0 oldest. Shifts on each pixel.
  logic [7:0] win_q [3][3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++) win_q[a][b] <= '0;
    end else if (adv && s1_vld_q) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2][0] <= pls_byp[7:0];
      win_q[2][1] <= pls_byp[15:8];
      win_q[2][2] <= s1_pix_q;
    end
  end
  logic [7:0] wcol2 [3];
  assign wcol2[0] = pls_byp[7:0];
  assign wcol2[1] = pls_byp[15:8];
  assign wcol2[2] = s1_pix_q;

  // Stage 2: gradients (window after shift), up to +/-4080.
  logic signed [12:0] s2_dx_q, s2_dy_q;
  logic        s2_vld_q, s2_grad_q, s2_emit_q, s2_last_q;
  logic [AW-1:0] s2_pc_q;
  logic [RW-1:0] s2_row_q;
  logic [CW-1:0] s2_col_q;
  logic signed [12:0] dx_c, dy_c;
  always_comb begin
    // New window: col0 = win_q[1], col1 = win_q[2], col2 = wcol2.
    dx_c = 13'sd10 * (13'($signed({1'b0, win_q[1][1]})) - 13'($signed({1'b0, wcol2[1]})))
         + 13'sd3 * (13'($signed({1'b0, win_q[1][0]})) - 13'($signed({1'b0, wcol2[0]})))
         + 13'sd3 * (13'($signed({1'b0, win_q[1][2]})) - 13'($signed({1'b0, wcol2[2]})));
    dy_c = 13'sd10 * (13'($signed({1'b0, win_q[2][0]})) - 13'($signed({1'b0, win_q[2][2]})))
         + 13'sd3 * (13'($signed({1'b0, win_q[1][0]})) - 13'($signed({1'b0, win_q[1][2]})))
         + 13'sd3 * (13'($signed({1'b0, wcol2[0]})) - 13'($signed({1'b0, wcol2[2]})));
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else if (adv) s2_vld_q <= s1_vld_q && s1_grad_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_dx_q <= dx_c;
      s2_dy_q <= dy_c;
      s2_pc_q <= AW'(s1_addr_q - 1'b1);
      s2_emit_q <= s1_emit_q;
      s2_last_q <= s1_last_q;
      s2_row_q <= s1_row_q;
      s2_col_q <= s1_col_q;
    end
  end

  // Stage 3: products with floor shift by 10; product store read.
  logic signed [24:0] pxx, pyy, pxy;
  assign pxx = 25'(s2_dx_q) * 25'(s2_dx_q);
  assign pyy = 25'(s2_dy_q) * 25'(s2_dy_q);
  assign pxy = 25'(s2_dx_q) * 25'(s2_dy_q);
  logic signed [15:0] s3_xx_q, s3_yy_q, s3_xy_q;
  logic s3_vld_q, s3_emit_q, s3_last_q;
  logic [AW-1:0] s3_pc_q;
  logic [RW-1:0] s3_row_q;
  logic [CW-1:0] s3_col_q;
  logic [95:0] prd_rd, prd_use;
  logic pbyp_q;
  logic [95:0] pbyp_data_q;
  logic [47:0] np3;
  assign np3 = {s3_xx_q, s3_yy_q, s3_xy_q};

  hcs_ram #(.Width(96), .Depth(MAX_WIDTH)) u_prod_line (
    .clk_i   (clk_i),
    .we_i    (s3_vld_q && adv),
    .waddr_i (s3_pc_q),
    .wdata_i ({np3, prd_use[95:48]}),
    .re_i    (adv && s2_vld_q),
    .raddr_i (s2_pc_q),
    .rdata_o (prd_rd)
  );
  assign prd_use = pbyp_q ? pbyp_data_q : prd_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
      pbyp_q   <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= s2_vld_q;
      pbyp_q   <= s2_vld_q && s3_vld_q && (s3_pc_q == s2_pc_q);
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pbyp_data_q <= {np3, prd_use[95:48]};
      s3_xx_q <= 16'(pxx >>> 10);
      s3_yy_q <= 16'(pyy >>> 10);
      s3_xy_q <= 16'(pxy >>> 10);
      s3_pc_q <= s2_pc_q;
      s3_emit_q <= s2_emit_q;
      s3_last_q <= s2_last_q;
      s3_row_q <= s2_row_q;
      s3_col_q <= s2_col_q;
    end
  end

  // Product window: [col][kind]; 1-2-1 row-weighted column sums formed as
  // each column enters, then a 1-2-1 across columns.
  logic signed [17:0] cs_q [3][3];
  logic signed [17:0] cs_new [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cs_new[k] = 18'($signed(prd_use[k*16 +: 16]))
                + 18'($signed(prd_use[48 + k*16 +: 16])) * 18'sd2
                + 18'($signed(np3[k*16 +: 16]));
    end
  end
  // kind order in words: bits [47:32]=xx, [31:16]=yy, [15:0]=xy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++)
        for (int k = 0; k < 3; k++) cs_q[a][k] <= '0;
    end else if (adv && s3_vld_q) begin
      cs_q[0] <= cs_q[1];
      cs_q[1] <= cs_q[2];
      cs_q[2] <= cs_new;
    end
  end
  logic s4_vld_q, s4_last_q;
  logic [RW-1:0] s4_row_q;
  logic [CW-1:0] s4_col_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_vld_q <= 1'b0;
    else if (adv) s4_vld_q <= s3_vld_q && s3_emit_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_last_q <= s3_last_q;
      s4_row_q <= s3_row_q;
      s4_col_q <= s3_col_q;
    end
  end

  // Stage 5: horizontal 1-2-1 and floor shift by 4.
  logic signed [19:0] sm [3];
  always_comb begin
    for (int k = 0; k < 3; k++)
      sm[k] = 20'(cs_q[0][k]) + 20'(cs_q[1][k]) * 20'sd2 + 20'(cs_q[2][k]);
  end
  logic signed [15:0] s5_xx_q, s5_yy_q, s5_xy_q;
  hcs_pkg::ctl_t s5_q, s6_q, s7_q, s8_q, s9_q, s10_q, s11_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_q <= '0;
    end else if (adv) begin
      s5_q.vld  <= s4_vld_q;
      s5_q.emit <= 1'b1;
      s5_q.last <= s4_last_q;
      s5_q.row  <= s4_row_q;
      s5_q.col  <= s4_col_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_xx_q <= 16'(sm[2] >>> 4);
      s5_yy_q <= 16'(sm[1] >>> 4);
      s5_xy_q <= 16'(sm[0] >>> 4);
    end
  end

  // Stage 6: two products and the half trace.
  logic signed [31:0] s6_xxyy_q, s6_xyxy_q;
  logic [15:0] s6_tr_q;
  logic signed [16:0] tsum;
  assign tsum = 17'(s5_xx_q) + 17'(s5_yy_q);
  // Stage 7: tr^2 and difference.
  logic [31:0] s7_tt_q;
  logic signed [32:0] s7_d_q;
  // Stages 8-9: divide tr^2 by 5 via reciprocal 0xCCCCCCCD >> 34; stage 10 subtracts.
  logic [63:0] s8_m_q;
  logic signed [32:0] s8_d_q, s9_d_q;
  logic [31:0] s9_q5_q;
  logic signed [31:0] s10_sc_q, s11_sc_q;
  logic [63:0] mprod;
  // Split 32x32: tt * 0xCCCCCCCD = tt*0xCCCC<<16 + tt*0xCCCD.
  logic [47:0] s8_lo_q, s8_hi_q;
  assign mprod = (64'(s8_hi_q) << 16) + 64'(s8_lo_q);

  // Advance the control words alongside the arithmetic.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_q <= '0; s7_q <= '0; s8_q <= '0;
      s9_q <= '0; s10_q <= '0;
    end else if (adv) begin
      s6_q <= s5_q; s7_q <= s6_q; s8_q <= s7_q;
      s9_q <= s8_q; s10_q <= s9_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_xxyy_q <= s5_xx_q * s5_yy_q;
      s6_xyxy_q <= s5_xy_q * s5_xy_q;
      s6_tr_q   <= 16'(tsum >>> 1);
      s7_tt_q   <= 32'(s6_tr_q) * 32'(s6_tr_q);
      s7_d_q    <= 33'(s6_xxyy_q) - 33'(s6_xyxy_q);
      s8_lo_q   <= 48'(s7_tt_q) * 48'h0000_CCCD;
      s8_hi_q   <= 48'(s7_tt_q) * 48'h0000_CCCC;
      s8_d_q    <= s7_d_q;
      s9_q5_q   <= 32'(mprod >> 34);
      s9_d_q    <= s8_d_q;
      s10_sc_q  <= 32'(s9_d_q - 33'($signed({1'b0, s9_q5_q})));
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s11_q <= '0;
    end else if (adv) begin
      s11_q.vld  <= s10_q.vld && s10_q.emit;
      s11_q.emit <= s10_q.emit;
      s11_q.last <= s10_q.last;
      s11_q.row  <= s10_q.row;
      s11_q.col  <= s10_q.col;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s11_sc_q <= s10_sc_q;
    end
  end

  assign score_valid_o = s11_q.vld;
  assign score_o       = s11_sc_q;
  assign score_row_o   = s11_q.row;
  assign score_col_o   = s11_q.col;
  assign frame_last_o  = s11_q.last;

  logic unused_ok;
  assign unused_ok = ^{NST[0], s11_q.emit};
endmodule
`default_nettype wire

>>> rtl/hcs_checker.sv
// ---------------------------------------------------------------------------
// hcs_checker
// Port-level checks on the Harris corner score unit.
// ---------------------------------------------------------------------------
`default_nettype none
`include "harris_corner_score_unit_assert.svh"
module hcs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        pixel_valid_i,
  input wire logic        pixel_ready_o,
  input wire logic        score_valid_o,
  input wire logic        score_ready_i,
  input wire logic [31:0] score_o,
  input wire logic [11:0] score_row_o,
  input wire logic [10:0] score_col_o,
  input wire logic        frame_last_o
);
  `HCS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, score_valid_o && !score_ready_i,
    score_valid_o && $stable(score_o) && $stable(score_row_o))
  `HCS_ASSERT_IMPL(a_stall_blocks, clk_i, rst_ni, score_valid_o && !score_ready_i,
    !pixel_ready_o)
  `HCS_ASSERT_IMPL(a_row_range, clk_i, rst_ni, score_valid_o,
    score_row_o >= 12'd2 && score_col_o >= 11'd2)
  `HCS_ASSERT_NEXT(a_last_next, clk_i, rst_ni,
    score_valid_o && score_ready_i && frame_last_o,
    !score_valid_o || score_row_o == 12'd2)
endmodule
bind harris_corner_score_unit hcs_checker u_hcs_checker (.*);
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for harris_corner_score_unit
// Streams pixel frames of many sizes, predicts every interior corner score
// in the bench and compares each score word field by field, with random
// idling on the pixel side and random back-pressure on the score side.
// ----------------------------------------------------------------------------
module tb_top;
  localparam int unsigned MaxW    = hcs_pkg::MaxWidthDef;
  localparam int unsigned MaxH    = hcs_pkg::MaxHeightDef;
  localparam int unsigned CfgW    = hcs_pkg::CfgW;
  localparam int unsigned PixW    = hcs_pkg::PixW;
  localparam int unsigned ProdW   = hcs_pkg::ProdW;
  localparam int unsigned ScoreW  = hcs_pkg::ScoreW;
  localparam int unsigned RowW    = hcs_pkg::RowW;
  localparam int unsigned ColW    = hcs_pkg::ColW;
  localparam int unsigned ItemCnt = 1950;

  // Frame contents used by the directed and random phases.
  typedef enum int {
    PAT_RANDOM, PAT_FLAT_LO, PAT_FLAT_HI, PAT_CHECKER, PAT_VEDGE, PAT_HEDGE, PAT_RAMP
  } pattern_e;

  typedef struct {
    logic signed [ScoreW-1:0] score;
    logic [RowW-1:0]          row;
    logic [ColW-1:0]          col;
    logic                     last;
  } score_word_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_we_i      = 1'b0;
  logic [0:0]               cfg_idx_i     = hcs_pkg::CFG_WIDTH;
  logic [CfgW-1:0]          cfg_data_i    = '0;
  logic                     pixel_valid_i = 1'b0;
  logic                     pixel_ready_o;
  logic [PixW-1:0]          pixel_i       = '0;
  logic                     score_valid_o;
  logic                     score_ready_i = 1'b0;
  logic signed [ScoreW-1:0] score_o;
  logic [RowW-1:0]          score_row_o;
  logic [ColW-1:0]          score_col_o;
  logic                     frame_last_o;

  harris_corner_score_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .pixel_valid_i(pixel_valid_i),
    .pixel_ready_o(pixel_ready_o),
    .pixel_i      (pixel_i),
    .score_valid_o(score_valid_o),
    .score_ready_i(score_ready_i),
    .score_o      (score_o),
    .score_row_o  (score_row_o),
    .score_col_o  (score_col_o),
    .frame_last_o (frame_last_o)
  );

  // Bench copy of the block state.
  logic [PixW-1:0]         pix_line [MaxW][2];
  logic signed [ProdW-1:0] prod_line [MaxW][2][3];
  logic [PixW-1:0]         pix_win [3][3];
  logic signed [ProdW-1:0] prod_win [3][3][3];
  int unsigned             row_cnt, col_cnt;
  int unsigned             width_reg, height_reg;

  score_word_t score_q[$];   // scores still owed by the block
  int          err_cnt;
  int          pixel_cnt;
  int          score_cnt;
  int          frame_cnt;
  bit          idle_en;       // random idling on both sides when set

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #1ms;
    $display("harris_corner_score_unit: mismatch");
    $finish;
  end

  function automatic int smooth_prod(int k);
    int s;
    int wt[3];
    wt = '{1, 2, 1};
    s = 0;
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        s += wt[a] * wt[b] * int'(prod_win[a][b][k]);
    return s >>> 4;
  endfunction

  // Advance the bench state by one pixel and queue the score it completes.
  function automatic void predict_score(logic [PixW-1:0] p);
    int unsigned w, h, r, c, pc;
    int dx, dy;
    logic signed [ProdW-1:0] np[3];
    longint xx, yy, xy, tr, sc;
    score_word_t sw;
    w = (width_reg < 1) ? 1 : (width_reg > MaxW) ? MaxW : width_reg;
    h = (height_reg < 1) ? 1 : (height_reg > MaxH) ? MaxH : height_reg;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    r = row_cnt;
    c = col_cnt;
    pix_win[0] = pix_win[1];
    pix_win[1] = pix_win[2];
    pix_win[2][0] = pix_line[c][0];
    pix_win[2][1] = pix_line[c][1];
    pix_win[2][2] = p;
    pix_line[c][0] = pix_line[c][1];
    pix_line[c][1] = p;
    if (r >= 2 && c >= 2) begin
      dx = 10 * (int'(pix_win[0][1]) - int'(pix_win[2][1]))
         + 3 * (int'(pix_win[0][0]) - int'(pix_win[2][0]))
         + 3 * (int'(pix_win[0][2]) - int'(pix_win[2][2]));
      dy = 10 * (int'(pix_win[1][0]) - int'(pix_win[1][2]))
         + 3 * (int'(pix_win[0][0]) - int'(pix_win[0][2]))
         + 3 * (int'(pix_win[2][0]) - int'(pix_win[2][2]));
      np[0] = ProdW'((dx * dx) >>> 10);
      np[1] = ProdW'((dy * dy) >>> 10);
      np[2] = ProdW'((dx * dy) >>> 10);
      pc = c - 1;
      prod_win[0] = prod_win[1];
      prod_win[1] = prod_win[2];
      for (int k = 0; k < 3; k++) begin
        prod_win[2][0][k] = prod_line[pc][0][k];
        prod_win[2][1][k] = prod_line[pc][1][k];
        prod_win[2][2][k] = np[k];
        prod_line[pc][0][k] = prod_line[pc][1][k];
        prod_line[pc][1][k] = np[k];
      end
      if (r >= 4 && c >= 4) begin
        xx = smooth_prod(0);
        yy = smooth_prod(1);
        xy = smooth_prod(2);
        tr = (xx + yy) / 2;
        sc = xx * yy - xy * xy - (tr * tr) / 5;
        sw.score = sc[ScoreW-1:0];
        sw.row   = RowW'(r - 2);
        sw.col   = ColW'(c - 2);
        sw.last  = (r == h - 1 && c == w - 1);
        score_q.push_back(sw);
      end
    end
    col_cnt = c + 1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  // Score side: random back-pressure, compare each accepted word in order.
  always @(posedge clk_i) begin
    score_word_t sw;
    if (rst_ni && score_valid_o && score_ready_i) begin
      score_cnt++;
      if (score_q.size() == 0) begin
        report_mismatch("unexpected score word at row", score_row_o, -1);
      end else begin
        sw = score_q.pop_front();
        if (score_o !== sw.score) report_mismatch("score", score_o, sw.score);
        if (score_row_o !== sw.row) report_mismatch("score_row", score_row_o, sw.row);
        if (score_col_o !== sw.col) report_mismatch("score_col", score_col_o, sw.col);
        if (frame_last_o !== sw.last) report_mismatch("frame_last", frame_last_o, sw.last);
      end
    end
    score_ready_i <= !idle_en || ($urandom_range(99) >= 30);
  end

  // Send one pixel word; valid stays up across back-to-back words.
  task automatic send_pixel(logic [PixW-1:0] p);
    while (idle_en && $urandom_range(99) < 30) begin
      pixel_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    pixel_valid_i <= 1'b1;
    pixel_i       <= p;
    do @(posedge clk_i); while (!pixel_ready_o);
    predict_score(p);
    pixel_cnt++;
  endtask

  // Drop valid, drain all owed scores, then let the pipeline settle.
  task automatic wait_idle();
    pixel_valid_i <= 1'b0;
    while (score_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic cfg_write(hcs_pkg::cfg_idx_e idx, int unsigned val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgW'(val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == hcs_pkg::CFG_WIDTH) width_reg = val & 12'hFFF;
    else height_reg = val & 12'hFFF;
  endtask

  function automatic logic [PixW-1:0] pick_pixel(pattern_e pat, int r, int c);
    case (pat)
      PAT_FLAT_LO: return 8'h00;
      PAT_FLAT_HI: return 8'hFF;
      PAT_CHECKER: return ((r + c) % 2) ? 8'hFF : 8'h00;
      PAT_VEDGE:   return (c % 4 < 2) ? 8'hFF : 8'h00;
      PAT_HEDGE:   return (r % 3 == 0) ? 8'h00 : 8'hFF;
      PAT_RAMP:    return PixW'(r * 37 + c * 11);
      default: begin
        // lean toward the extremes so gradients get large
        case ($urandom_range(3))
          0: return 8'h00;
          1: return 8'hFF;
          default: return PixW'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic send_frame(int w, int h, pattern_e pat);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        send_pixel(pick_pixel(pat, r, c));
    frame_cnt++;
  endtask

  task automatic set_size(int unsigned w, int unsigned h);
    cfg_write(hcs_pkg::CFG_WIDTH, w);
    cfg_write(hcs_pkg::CFG_HEIGHT, h);
  endtask

  // Long rows through both line stores.
  task automatic test_wide_frame();
    set_size(80, 5);
    send_frame(80, 5, PAT_RANDOM);
    wait_idle();
  endtask

  // Smallest frame with one score, through every fixed pattern.
  task automatic test_min_frames();
    set_size(5, 5);
    for (int pat = PAT_FLAT_LO; pat <= PAT_RAMP; pat++)
      send_frame(5, 5, pattern_e'(pat));
    wait_idle();
  endtask

  // Dense scores with no idling on either side for the whole frame.
  task automatic test_tall_frame();
    set_size(5, 80);
    idle_en = 1'b0;
    send_frame(5, 80, PAT_RANDOM);
    wait_idle();
    idle_en = 1'b1;
  endtask

  // Sizes below five give no interior.
  task automatic test_clamped_sizes();
    set_size(3, 3);
    repeat (20) send_pixel(PixW'($urandom));
    wait_idle();
    set_size(0, 0);
    repeat (10) send_pixel(PixW'($urandom));
    wait_idle();
  endtask

  task automatic test_random_frames();
    int w, h;
    while (pixel_cnt < ItemCnt) begin
      w = $urandom_range(5, 12);
      h = $urandom_range(5, 9);
      set_size(w, h);
      repeat ($urandom_range(1, 2))
        send_frame(w, h, ($urandom_range(3) == 0) ?
                   pattern_e'($urandom_range(PAT_FLAT_LO, PAT_RAMP)) : PAT_RANDOM);
      wait_idle();
    end
  endtask

  initial begin
    for (int i = 0; i < MaxW; i++)
      for (int j = 0; j < 2; j++) begin
        pix_line[i][j] = '0;
        for (int k = 0; k < 3; k++) prod_line[i][j][k] = '0;
      end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        pix_win[i][j] = '0;
        for (int k = 0; k < 3; k++) prod_win[i][j][k] = '0;
      end
    row_cnt    = 0;
    col_cnt    = 0;
    width_reg  = 640;
    height_reg = 480;
    idle_en    = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_wide_frame();
    test_min_frames();
    test_tall_frame();
    test_clamped_sizes();
    test_random_frames();

    $display("Sent %0d pixels in %0d frames of sizes from 5x5 to 80x5 and 5x80,",
             pixel_cnt, frame_cnt);
    $display("plus sizes below five; checked %0d scores under idling and back-pressure.",
             score_cnt);
    if (err_cnt == 0 && score_q.size() == 0) begin
      $display("harris_corner_score_unit: match");
    end else begin
      $display("harris_corner_score_unit: mismatch");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/hcs_pkg.sv
rtl/hcs_ram.sv
rtl/harris_corner_score_unit.sv
rtl/hcs_checker.sv
sim/tb_top.sv
